// File: hdl/base64_codec_unit_defines.svh
// Assertion helpers for the base64 codec.
`ifndef BASE64_CODEC_UNIT_DEFINES_SVH
`define BASE64_CODEC_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: hdl/b64c_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package b64c_pkg;

  localparam logic [7:0] CHAR_PAD   = 8'h3D; // '='
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
  localparam logic [7:0] CHAR_D0    = 8'h30;
  localparam logic [7:0] CHAR_D9    = 8'h39;

  // Up to four result bytes produced by one input transaction.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26)      c = CHAR_UC_A + {2'b00, v};
    else if (v < 6'd52) c = CHAR_LC_A + {2'b00, v - 6'd26};
    else if (v < 6'd62) c = CHAR_D0 + {2'b00, v - 6'd52};
    else if (v == 6'd62) c = CHAR_PLUS;
    else                c = CHAR_SLASH;
    return c;
  endfunction

  // Bit 6 set marks a character outside the alphabet.
  function automatic logic [6:0] char_sextet(input logic [7:0] c);
    logic [6:0] s;
    if (c >= CHAR_UC_A && c <= CHAR_UC_Z)      s = {1'b0, 6'(c - CHAR_UC_A)};
    else if (c >= CHAR_LC_A && c <= CHAR_LC_Z) s = {1'b0, 6'(c - CHAR_LC_A + 8'd26)};
    else if (c >= CHAR_D0 && c <= CHAR_D9)     s = {1'b0, 6'(c - CHAR_D0 + 8'd52)};
    else if (c == CHAR_PLUS)                   s = 7'd62;
    else if (c == CHAR_SLASH)                  s = 7'd63;
    else                                       s = 7'h40;
    return s;
  endfunction

endpackage

`default_nettype wire

// File: hdl/base64_codec_unit.sv
// Streaming Base64 codec, standard alphabet. cfg_direction selects encode (0)
// or decode (1); writing it drops any partial group. An input transaction is
// taken whenever the job queue (QUEUE_DEPTH jobs) has room, and its results (up
// to four) leave one per cycle from the output register while out_ready is high.
// Encoding is paced by the output port, as three bytes give four characters;
// decoding takes one character a cycle unless the queue is full, as four
// characters give only three bytes. An item that flushes a padded group gives
// four characters. An item's first result passes through the job queue and then
// the output register. out_run_last marks the final result of each item; items
// that produce nothing leave no trace on the output. No clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "base64_codec_unit_defines.svh"

module base64_codec_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_direction,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_message_end,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_run_last
);

  b64c_pkg::push_t push;
  b64c_pkg::job_t  head;
  logic            q_full, head_valid, pop, in_fire;
  logic            last_leaving;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign in_fire   = in_valid && in_ready;

  // final byte of a job leaves with nothing queued behind it
  assign last_leaving = out_valid && out_ready && out_run_last && !head_valid;

  b64c_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_dir     (cfg_direction),
    .in_fire     (in_fire),
    .data_byte   (in_data_byte),
    .message_end (in_message_end),
    .push        (push)
  );

  b64c_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  b64c_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_run_last (out_run_last)
  );

  `ASSERT_IMPL(a_no_overflow, clk, rst_n, push.valid, !q_full)
  `ASSERT_IMPL(a_pop_has_data, clk, rst_n, pop, head_valid)
  `ASSERT_NEXT(a_drain_idle, clk, rst_n, last_leaving, !out_valid)

endmodule

`default_nettype wire

// File: hdl/b64c_front.sv
`timescale 1ns / 1ps
`default_nettype none

module b64c_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_we,
  input  wire logic           cfg_dir,
  input  wire logic           in_fire,
  input  wire logic [7:0]     data_byte,
  input  wire logic           message_end,
  output b64c_pkg::push_t     push
);

  logic        direction_r;
  logic [1:0]  gc_r, gc_nxt;
  logic [17:0] held_r, held_nxt;
  logic        stopped_r, stopped_nxt;

  logic [6:0]  sx;
  logic [1:0]  flush_gc;
  logic [17:0] flush_held;
  logic        do_flush;
  logic [2:0]  n_res;
  b64c_pkg::job_t job;

  always_comb begin
    sx          = b64c_pkg::char_sextet(data_byte);
    gc_nxt      = gc_r;
    held_nxt    = held_r;
    stopped_nxt = stopped_r;
    job         = '0;
    n_res       = 3'd0;
    do_flush    = 1'b0;
    flush_gc    = gc_r;
    flush_held  = held_r;

    if (!direction_r) begin
      if (gc_r >= 2'd2) begin
        job.bytes[0] = b64c_pkg::sextet_char(held_r[15:10]);
        job.bytes[1] = b64c_pkg::sextet_char(held_r[9:4]);
        job.bytes[2] = b64c_pkg::sextet_char({held_r[3:0], data_byte[7:6]});
        job.bytes[3] = b64c_pkg::sextet_char(data_byte[5:0]);
        n_res    = 3'd4;
        gc_nxt   = 2'd0;
        held_nxt = '0;
      end else begin
        held_nxt = {held_r[9:0], data_byte};
        gc_nxt   = gc_r + 2'd1;
      end
      if (message_end) begin
        if (gc_nxt == 2'd1) begin
          job.bytes[0] = b64c_pkg::sextet_char(held_nxt[7:2]);
          job.bytes[1] = b64c_pkg::sextet_char({held_nxt[1:0], 4'b0000});
          job.bytes[2] = b64c_pkg::CHAR_PAD;
          job.bytes[3] = b64c_pkg::CHAR_PAD;
          n_res        = 3'd4;
        end else if (gc_nxt == 2'd2) begin
          job.bytes[0] = b64c_pkg::sextet_char(held_nxt[15:10]);
          job.bytes[1] = b64c_pkg::sextet_char(held_nxt[9:4]);
          job.bytes[2] = b64c_pkg::sextet_char({held_nxt[3:0], 2'b00});
          job.bytes[3] = b64c_pkg::CHAR_PAD;
          n_res        = 3'd4;
        end
      end
    end else if (!stopped_r) begin
      if (!sx[6]) begin
        if (gc_r == 2'd3) begin
          job.bytes[0] = held_r[17:10];
          job.bytes[1] = held_r[9:2];
          job.bytes[2] = {held_r[1:0], sx[5:0]};
          n_res    = 3'd3;
          gc_nxt   = 2'd0;
          held_nxt = '0;
        end else begin
          held_nxt = {held_r[11:0], sx[5:0]};
          gc_nxt   = gc_r + 2'd1;
        end
        do_flush   = message_end;
        flush_gc   = gc_nxt;
        flush_held = held_nxt;
      end else begin
        // '=' or stray character: flush what is held and stop
        do_flush    = 1'b1;
        stopped_nxt = 1'b1;
      end
      if (do_flush) begin
        if (flush_gc == 2'd2) begin
          job.bytes[0] = flush_held[11:4];
          n_res        = 3'd1;
        end else if (flush_gc == 2'd3) begin
          job.bytes[0] = flush_held[17:10];
          job.bytes[1] = flush_held[9:2];
          n_res        = 3'd2;
        end
        gc_nxt   = 2'd0;
        held_nxt = '0;
      end
    end

    if (message_end) begin
      gc_nxt      = 2'd0;
      held_nxt    = '0;
      stopped_nxt = 1'b0;
    end

    job.last_idx = 2'(n_res - 3'd1);
    push.valid   = in_fire && (n_res != 3'd0);
    push.job     = job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= 1'b0;
      gc_r        <= 2'd0;
      held_r      <= '0;
      stopped_r   <= 1'b0;
    end else if (cfg_we) begin
      direction_r <= cfg_dir;
      gc_r        <= 2'd0;
      held_r      <= '0;
      stopped_r   <= 1'b0;
    end else if (in_fire) begin
      gc_r        <= gc_nxt;
      held_r      <= held_nxt;
      stopped_r   <= stopped_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/b64c_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module b64c_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire b64c_pkg::push_t push,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output b64c_pkg::job_t      head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  b64c_pkg::job_t    slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push, do_pop;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = slot_r[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head_valid;

  function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push.job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wrap_inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= wrap_inc(rd_ptr_r);
      if (do_push && !do_pop)      count_r <= count_r + CNT_W'(1);
      else if (do_pop && !do_push) count_r <= count_r - CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// File: hdl/b64c_back.sv
`timescale 1ns / 1ps
`default_nettype none

module b64c_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           head_valid,
  input  wire b64c_pkg::job_t head,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_byte,
  output logic                out_run_last
);

  logic           busy_r;
  b64c_pkg::job_t job_r;
  logic [1:0]     idx_r;
  logic           fire, at_end;

  assign out_valid    = busy_r;
  assign out_byte     = job_r.bytes[idx_r];
  assign at_end       = (idx_r == job_r.last_idx);
  assign out_run_last = at_end;
  assign fire         = busy_r && out_ready;
  // next job loads when idle or as the final byte of the current one leaves
  assign pop          = head_valid && (!busy_r || (fire && at_end));

  always_ff @(posedge clk) begin
    if (pop) job_r <= head;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else if (pop) begin
      busy_r <= 1'b1;
      idx_r  <= 2'd0;
    end else if (fire) begin
      if (at_end) busy_r <= 1'b0;
      else        idx_r  <= idx_r + 2'd1;
    end
  end

endmodule

`default_nettype wire

// File: bench/base64_codec_unit_test.sv
`timescale 1ns / 1ps

module base64_codec_unit_test;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 16;
  localparam int LONG_HOLD     = 120;
  localparam int PHASE_ITEMS   = 66;

  localparam logic [8*64-1:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] value;
    logic       run_last;
  } codec_result_t;

  typedef enum logic {ROW_ITEM, ROW_DIRECTION} row_kind_t;

  // known: expected output typed in below rather than taken from the predictor
  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  data;
    logic        fin;
    logic        known;
    logic [2:0]  known_n;
    logic [31:0] known_bytes;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_direction = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte = 8'h00;
  logic       in_message_end = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_run_last;

  // predictor state
  logic        codec_dir = DIR_ENCODE;
  logic [1:0]  codec_count = 2'd0;
  logic [17:0] codec_held = '0;
  logic        codec_stopped = 1'b0;

  codec_result_t step_results [$];
  codec_result_t pending_outputs [$];

  int          mismatch_count = 0;
  int          cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests = 0;

  stim_row_t directed_rows [$] = '{
    '{ROW_ITEM, 8'h00, 1'b0, 1'b1, 3'd0, 32'h0},
    '{ROW_ITEM, 8'h00, 1'b0, 1'b1, 3'd0, 32'h0},
    '{ROW_ITEM, 8'h00, 1'b0, 1'b1, 3'd4, "AAAA"},
    '{ROW_ITEM, 8'hFF, 1'b0, 1'b0, 3'd0, 32'h0},
    '{ROW_ITEM, 8'hFF, 1'b0, 1'b0, 3'd0, 32'h0},
    '{ROW_ITEM, 8'hFF, 1'b0, 1'b1, 3'd4, "////"},
    '{ROW_ITEM, 8'hFF, 1'b1, 1'b1, 3'd4, "/w=="},
    '{ROW_ITEM, 8'h4D, 1'b0, 1'b0, 3'd0, 32'h0},
    '{ROW_ITEM, 8'h61, 1'b1, 1'b0, 3'd0, 32'h0},
    '{ROW_DIRECTION, 8'(DIR_DECODE), 1'b0, 1'b0, 3'd0, 32'h0},
    '{ROW_ITEM, 8'h54, 1'b0, 1'b0, 3'd0, 32'h0},
    '{ROW_ITEM, 8'h57, 1'b0, 1'b0, 3'd0, 32'h0},
    '{ROW_ITEM, 8'h46, 1'b0, 1'b0, 3'd0, 32'h0},
    '{ROW_ITEM, 8'h75, 1'b1, 1'b1, 3'd3, 32'h4D616E00},
    // lone character left at message end gives nothing
    '{ROW_ITEM, 8'h41, 1'b1, 1'b1, 3'd0, 32'h0},
    // pad stops the decoder, rest ignored up to message end
    '{ROW_ITEM, 8'h54, 1'b0, 1'b0, 3'd0, 32'h0},
    '{ROW_ITEM, 8'h57, 1'b0, 1'b0, 3'd0, 32'h0},
    '{ROW_ITEM, b64c_pkg::CHAR_PAD, 1'b0, 1'b0, 3'd0, 32'h0},
    '{ROW_ITEM, 8'h51, 1'b0, 1'b1, 3'd0, 32'h0},
    '{ROW_ITEM, 8'h51, 1'b1, 1'b1, 3'd0, 32'h0},
    // non-alphabet byte on the closing transaction
    '{ROW_ITEM, 8'h54, 1'b0, 1'b0, 3'd0, 32'h0},
    '{ROW_ITEM, 8'h57, 1'b0, 1'b0, 3'd0, 32'h0},
    '{ROW_ITEM, 8'h46, 1'b0, 1'b0, 3'd0, 32'h0},
    '{ROW_ITEM, 8'h80, 1'b1, 1'b0, 3'd0, 32'h0},
    // direction change drops a half-built group
    '{ROW_ITEM, 8'h54, 1'b0, 1'b0, 3'd0, 32'h0},
    '{ROW_DIRECTION, 8'(DIR_ENCODE), 1'b0, 1'b0, 3'd0, 32'h0},
    '{ROW_ITEM, 8'h01, 1'b1, 1'b1, 3'd4, "AQ=="}
  };

  base64_codec_unit u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_direction (cfg_direction),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_message_end(in_message_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_run_last  (out_run_last)
  );

  initial forever #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("base64_codec_unit regression: fail");
      $finish;
    end
  end

  function automatic void add_step_result(codec_result_t r);
    step_results.insert(step_results.size(), r);
  endfunction

  function automatic void add_expected(codec_result_t r);
    pending_outputs.insert(pending_outputs.size(), r);
  endfunction

  function automatic logic [7:0] alpha_char(logic [5:0] v);
    return B64_ALPHABET[8 * (63 - v) +: 8];
  endfunction

  // bit 6 set: not in the alphabet
  function automatic logic [6:0] sextet_of(logic [7:0] c);
    for (int i = 0; i < 64; i++)
      if (alpha_char(6'(i)) == c) return 7'(i);
    return 7'h40;
  endfunction

  function automatic void flush_partial_group();
    logic [23:0] grp;
    grp = 24'(codec_held) << (6 * (4 - codec_count));
    if (codec_count >= 2'd2)
      for (int j = 0; j + 1 < codec_count; j++)
        add_step_result(codec_result_t'{grp[23 - 8*j -: 8], 1'b0});
    codec_count = 2'd0;
    codec_held  = '0;
  endfunction

  function automatic void clear_codec_state();
    codec_count   = 2'd0;
    codec_held    = '0;
    codec_stopped = 1'b0;
  endfunction

  function automatic void predict_codec_output(logic [7:0] d, logic fin);
    logic [23:0] grp;
    logic [6:0]  sx;
    int          n;
    step_results.delete();
    if (codec_dir == DIR_ENCODE) begin
      if (codec_count == 2'd2) begin
        grp = {codec_held[15:0], d};
        for (int s = 0; s < 4; s++)
          add_step_result(codec_result_t'{alpha_char(grp[23 - 6*s -: 6]), 1'b0});
        codec_count = 2'd0;
        codec_held  = '0;
      end else begin
        codec_held = {codec_held[9:0], d};
        codec_count++;
      end
      if (fin) begin
        n = codec_count;
        if (n != 0) begin
          grp = 24'(codec_held) << (8 * (3 - n));
          for (int s = 0; s <= n; s++)
            add_step_result(codec_result_t'{alpha_char(grp[23 - 6*s -: 6]), 1'b0});
          for (int s = n; s < 3; s++)
            add_step_result(codec_result_t'{b64c_pkg::CHAR_PAD, 1'b0});
        end
        clear_codec_state();
      end
    end else begin
      if (!codec_stopped) begin
        sx = sextet_of(d);
        if (!sx[6]) begin
          if (codec_count == 2'd3) begin
            grp = {codec_held, sx[5:0]};
            add_step_result(codec_result_t'{grp[23:16], 1'b0});
            add_step_result(codec_result_t'{grp[15:8], 1'b0});
            add_step_result(codec_result_t'{grp[7:0], 1'b0});
            codec_count = 2'd0;
            codec_held  = '0;
          end else begin
            codec_held = {codec_held[11:0], sx[5:0]};
            codec_count++;
          end
          if (fin) flush_partial_group();
        end else begin
          flush_partial_group();
          codec_stopped = 1'b1;
        end
      end
      if (fin) clear_codec_state();
    end
    if (step_results.size() != 0) step_results[$].run_last = 1'b1;
  endfunction

  // Called just after a rising edge; in_valid is never lowered at the accepting
  // edge, so a back-to-back transaction sees a single assignment per step.
  task automatic send_item(logic [7:0] d, logic fin, logic known, logic [2:0] known_n,
                           logic [31:0] known_bytes);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data_byte   <= d;
    in_message_end <= fin;
    do @(posedge clk); while (!in_ready);
    predict_codec_output(d, fin);
    if (known) begin
      for (int i = 0; i < known_n; i++)
        add_expected(codec_result_t'{known_bytes[31 - 8*i -: 8], i == known_n - 1});
    end else begin
      foreach (step_results[i]) add_expected(step_results[i]);
    end
  endtask

  task automatic wait_for_outputs();
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_direction(logic dir);
    cfg_valid     <= 1'b1;
    cfg_direction <= dir;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    codec_dir = dir;
    clear_codec_state();
  endtask

  // Mostly alphabet characters so groups complete; some pads and raw noise.
  function automatic logic [7:0] pick_codec_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return alpha_char(6'($urandom_range(63)));
    if (r < 88) return b64c_pkg::CHAR_PAD;
    return 8'($urandom_range(255));
  endfunction

  task automatic run_phase(logic dir, int unsigned send_pct, int unsigned stall_pct,
                           logic long_hold, logic pause_between);
    int          sent;
    int unsigned len;
    logic [7:0]  d;
    wait_for_outputs();
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    write_direction(dir);
    if (long_hold) hold_requests++;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      len = $urandom_range(1, 12);
      if (len > unsigned'(PHASE_ITEMS - sent)) len = unsigned'(PHASE_ITEMS - sent);
      for (int i = 0; i < len; i++) begin
        d = (dir == DIR_DECODE) ? pick_codec_char() : 8'($urandom_range(255));
        sent++;
        send_item(d, i == len - 1, 1'b0, 3'd0, 32'h0);
      end
      if (pause_between && $urandom_range(3) == 0) wait_for_outputs();
    end
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin : receiver
    int unsigned hold_left;
    int unsigned holds_served;
    hold_left    = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (holds_served != hold_requests) begin
        holds_served = hold_requests;
        hold_left    = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : out_check
    codec_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_outputs.size() == 0) begin
        $error("unexpected transaction: out_byte=%h out_run_last=%b", out_byte, out_run_last);
        mismatch_count++;
      end else begin
        want = pending_outputs.pop_front();
        if (out_byte !== want.value) begin
          $error("out_byte: expected %h, actual %h", want.value, out_byte);
          mismatch_count++;
        end
        if (out_run_last !== want.run_last) begin
          $error("out_run_last: expected %b, actual %b", want.run_last, out_run_last);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    stim_row_t row;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      if (row.kind == ROW_DIRECTION) begin
        wait_for_outputs();
        write_direction(row.data[0]);
      end else begin
        send_item(row.data, row.fin, row.known, row.known_n, row.known_bytes);
      end
    end

    run_phase(DIR_DECODE, 0, 0, 1'b0, 1'b0);
    run_phase(DIR_ENCODE, 0, 0, 1'b1, 1'b0);
    run_phase(DIR_DECODE, 60, 0, 1'b0, 1'b0);
    run_phase(DIR_ENCODE, 0, 60, 1'b0, 1'b0);
    run_phase(DIR_DECODE, 14, 14, 1'b1, 1'b1);
    run_phase(DIR_ENCODE, 14, 14, 1'b0, 1'b1);

    wait_for_outputs();
    if (mismatch_count == 0) begin
      $display("base64_codec_unit regression: pass");
    end else begin
      $display("base64_codec_unit regression: fail");
    end
    $finish;
  end

endmodule
